@@ rtl/vtf_pkg.sv @@
package vtf_pkg;

	localparam int MAX_CAMERAS = 16;
	localparam int CAM_W       = $clog2(MAX_CAMERAS + 1);
	localparam int DIV_STEPS   = 32;
	localparam int CNT_W       = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		ACT_START   = 2'd0,
		ACT_REPLACE = 2'd1,
		ACT_AVERAGE = 2'd2,
		ACT_IGNORE  = 2'd3
	} act_t;

	typedef struct packed {
		logic               start_new;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic        [31:0] pixel_size;
		logic signed [15:0] similarity;
		logic        [15:0] camera_id;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] fused_x;
		logic signed [31:0] fused_y;
		logic signed [31:0] fused_z;
		logic        [31:0] best_pixel_size;
		logic signed [15:0] best_similarity;
		logic        [31:0] point_count;
		logic        [4:0]  camera_count;
		logic               table_full;
		logic        [1:0]  action;
	} out_word_t;

	typedef struct packed {
		logic       load;
		logic       decide;
		logic       mul;
		logic       sum;
		logic       prep;
		logic       div_step;
		logic       div_last;
		logic       commit;
		logic       out_load;
		logic [1:0] coord;
	} vtf_cmd_t;

	typedef struct packed {
		logic avg_needed;
		logic out_free;
	} vtf_sts_t;

endpackage

@@ rtl/vtf_ctrl.sv @@
module vtf_ctrl import vtf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  vtf_sts_t sts,
	output vtf_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_DECIDE, S_MUL, S_SUM, S_PREP, S_DIV, S_DONE
	} state_t;

	state_t           state_q;
	logic [1:0]       coord_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last_w;

	assign last_w   = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.coord    = coord_q;
		cmd.load     = in_ready && in_valid;
		cmd.decide   = (state_q == S_DECIDE);
		cmd.mul      = (state_q == S_MUL);
		cmd.sum      = (state_q == S_SUM);
		cmd.prep     = (state_q == S_PREP);
		cmd.div_step = (state_q == S_DIV);
		cmd.div_last = (state_q == S_DIV) && last_w;
		cmd.commit   = (state_q == S_DIV) && last_w && (coord_q == 2'd2);
		cmd.out_load = (state_q == S_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			coord_q <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					coord_q <= '0;
					state_q <= sts.avg_needed ? S_MUL : S_DONE;
				end
				S_MUL: state_q <= S_SUM;
				S_SUM: state_q <= S_PREP;
				S_PREP: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_w) begin
						if (coord_q == 2'd2) begin
							state_q <= S_DONE;
						end else begin
							coord_q <= coord_q + 2'd1;
							state_q <= S_MUL;
						end
					end
				end
				S_DONE: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (coord_q <= 2'd2))
		else $error("coordinate index out of range");
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> in_ready)
		else $error("not idle after result load");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.load)
		else $error("word accepted while busy");

endmodule

@@ rtl/vtf_datapath.sv @@
module vtf_datapath import vtf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  in_word,
	input  vtf_cmd_t  cmd,
	input  logic      out_ready,
	output logic      out_valid,
	output out_word_t out_word,
	output vtf_sts_t  sts
);

	in_word_t           in_q;
	logic               track_valid_q;
	logic [31:0]        acc_count_q;
	logic signed [31:0] acc_point_q [3];
	logic [31:0]        acc_min_pixel_q;
	logic signed [15:0] acc_min_sim_q;
	logic [15:0]        cam_ids_q  [MAX_CAMERAS];
	logic [15:0]        cam_hits_q [MAX_CAMERAS];
	logic [CAM_W-1:0]   cam_used_q;
	logic               full_q;
	act_t               act_q;
	logic               out_valid_q;

	logic [63:0]        prod_s1;
	logic [63:0]        sum_q;
	logic               neg_q;
	logic [32:0]        rem_q;
	logic [31:0]        lo_q;

	logic                   start_w, found_w, drop_w, repl_w, avg_w;
	logic [MAX_CAMERAS-1:0] hit_w, less_w;
	logic [CAM_W-1:0]       pos_w;
	logic [34:0]            p5_w, m4_w, m6_w;
	logic [32:0]            d_w;
	logic signed [64:0]     mul_w;
	logic [31:0]            add_w;
	logic [63:0]            mag_w, num_w;
	logic [33:0]            t_w;
	logic                   ge_w;
	logic [31:0]            q_w, res_w;

	assign start_w = in_q.start_new || !track_valid_q;
	always_comb begin
		for (int i = 0; i < MAX_CAMERAS; i++) begin
			hit_w[i]  = (CAM_W'(i) < cam_used_q) && (cam_ids_q[i] == in_q.camera_id);
			less_w[i] = (CAM_W'(i) < cam_used_q) && (cam_ids_q[i] < in_q.camera_id);
		end
	end
	assign found_w = |hit_w;
	assign pos_w   = CAM_W'($countones(less_w));
	assign drop_w  = !found_w && (cam_used_q >= CAM_W'(MAX_CAMERAS));

	assign p5_w  = {1'b0, in_q.pixel_size, 2'b00} + {3'b000, in_q.pixel_size};
	assign m4_w  = {1'b0, acc_min_pixel_q, 2'b00};
	assign m6_w  = {1'b0, acc_min_pixel_q, 2'b00} + {2'b00, acc_min_pixel_q, 1'b0};
	assign repl_w = (p5_w < m4_w);
	assign avg_w  = !repl_w && (p5_w < m6_w);

	assign sts.avg_needed = !start_w && avg_w;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign d_w   = {1'b0, acc_count_q} + 33'd1;
	assign mul_w = acc_point_q[cmd.coord] * $signed({1'b0, acc_count_q});
	always_comb begin
		case (cmd.coord)
			2'd0:    add_w = in_q.pos_x;
			2'd1:    add_w = in_q.pos_y;
			default: add_w = in_q.pos_z;
		endcase
	end
	assign mag_w = sum_q[63] ? (~sum_q + 64'd1) : sum_q;
	assign num_w = mag_w + {32'd0, d_w[32:1]};
	assign t_w   = {rem_q, lo_q[31]};
	assign ge_w  = (t_w >= {1'b0, d_w});
	assign q_w   = {lo_q[30:0], ge_w};
	assign res_w = neg_q ? (~q_w + 32'd1) : q_w;

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_word;
		if (cmd.mul) prod_s1 <= mul_w[63:0];
		if (cmd.sum) sum_q <= prod_s1 + {{32{add_w[31]}}, add_w};
		if (cmd.prep) begin
			neg_q <= sum_q[63];
			rem_q <= {1'b0, num_w[63:32]};
			lo_q  <= num_w[31:0];
		end
		if (cmd.div_step) begin
			rem_q <= ge_w ? 33'(t_w - {1'b0, d_w}) : t_w[32:0];
			lo_q  <= q_w;
		end
		if (cmd.decide) begin
			if (start_w) begin
				cam_ids_q[0]  <= in_q.camera_id;
				cam_hits_q[0] <= 16'd1;
			end else if (found_w) begin
				for (int i = 0; i < MAX_CAMERAS; i++)
					if (hit_w[i] && cam_hits_q[i] != 16'hFFFF)
						cam_hits_q[i] <= cam_hits_q[i] + 16'd1;
			end else if (!drop_w) begin
				for (int i = 0; i < MAX_CAMERAS; i++) begin
					if (CAM_W'(i) == pos_w) begin
						cam_ids_q[i]  <= in_q.camera_id;
						cam_hits_q[i] <= 16'd1;
					end else if (i > 0 && CAM_W'(i) > pos_w && CAM_W'(i) <= cam_used_q) begin
						cam_ids_q[i]  <= cam_ids_q[(i > 0) ? i - 1 : 0];
						cam_hits_q[i] <= cam_hits_q[(i > 0) ? i - 1 : 0];
					end
				end
			end
		end
		if (cmd.out_load) begin
			out_word.fused_x         <= acc_point_q[0];
			out_word.fused_y         <= acc_point_q[1];
			out_word.fused_z         <= acc_point_q[2];
			out_word.best_pixel_size <= acc_min_pixel_q;
			out_word.best_similarity <= acc_min_sim_q;
			out_word.point_count     <= acc_count_q;
			out_word.camera_count    <= 5'(cam_used_q);
			out_word.table_full      <= full_q;
			out_word.action          <= act_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_valid_q   <= 1'b0;
			acc_count_q     <= '0;
			acc_point_q     <= '{default: '0};
			acc_min_pixel_q <= '0;
			acc_min_sim_q   <= '0;
			cam_used_q      <= '0;
			full_q          <= 1'b0;
			act_q           <= ACT_START;
			out_valid_q     <= 1'b0;
		end else begin
			if (cmd.decide) begin
				full_q <= !start_w && drop_w;
				if (start_w) begin
					cam_used_q <= CAM_W'(1);
				end else if (!found_w && !drop_w) begin
					cam_used_q <= cam_used_q + CAM_W'(1);
				end
				if (start_w || repl_w) begin
					track_valid_q   <= 1'b1;
					acc_count_q     <= 32'd1;
					acc_point_q[0]  <= in_q.pos_x;
					acc_point_q[1]  <= in_q.pos_y;
					acc_point_q[2]  <= in_q.pos_z;
					acc_min_pixel_q <= in_q.pixel_size;
					acc_min_sim_q   <= in_q.similarity;
				end
				if (start_w)     act_q <= ACT_START;
				else if (repl_w) act_q <= ACT_REPLACE;
				else if (avg_w)  act_q <= ACT_AVERAGE;
				else             act_q <= ACT_IGNORE;
			end
			if (cmd.div_last) acc_point_q[cmd.coord] <= res_w;
			if (cmd.commit) begin
				if (in_q.pixel_size < acc_min_pixel_q) acc_min_pixel_q <= in_q.pixel_size;
				if (in_q.similarity < acc_min_sim_q) acc_min_sim_q <= in_q.similarity;
				if (acc_count_q != 32'hFFFF_FFFF) acc_count_q <= acc_count_q + 32'd1;
			end
			if (cmd.out_load)   out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cam_used_q <= CAM_W'(MAX_CAMERAS))
		else $error("camera table overfilled");
	a_empty_no_track: assert property (@(posedge clk) disable iff (!arst_n)
		!track_valid_q |-> (cam_used_q == '0))
		else $error("cameras stored without a track");
	a_commit_avg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (act_q == ACT_AVERAGE))
		else $error("average committed for another action");

endmodule

@@ rtl/voxel_track_fusion_top.sv @@
// Voxel track fusion: folds 3D point observations of one voxel into a running
// track with a sorted table of cameras. One word in gives one word out. A start,
// replace or ignore goes straight from the decision to the result; an averaging
// step runs the shared multiplier and the restoring divider, which yields one
// quotient bit a cycle, once for each of the three coordinates. A new word is
// taken while the last result waits at the output.
module voxel_track_fusion_top import vtf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	vtf_cmd_t cmd;
	vtf_sts_t sts;

	vtf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vtf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cmd       (cmd),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_word  (out_word),
		.sts       (sts)
	);

endmodule
